// ===== hw/rtl/cwvac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Variant allele check package
// Shared widths, codes, walk state, queue item layout and nucleotide decoding.
// ---------------------------------------------------------------------------------------------
package cwvac_pkg;

   // Widths of cursors, sums and stream payloads
   localparam int POS_BITS       = 32;
   localparam int SUM_BITS       = ((POS_BITS > 32) ? POS_BITS : 32) + 1;
   localparam int REM_BITS       = 33;
   localparam int LEN_BITS       = 28;
   localparam int OFFSET_BITS    = 32;
   localparam int REQ_DATA_BITS  = 128;
   localparam int RSP_DATA_BITS  = 40;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_DEPTH    = 1 << QUEUE_PTR_BITS;

   // Input item kinds carried on tuser
   localparam logic [1:0] ACTION_HEADER = 2'd0;
   localparam logic [1:0] ACTION_CIGAR  = 2'd1;
   localparam logic [1:0] ACTION_BASE   = 2'd2;

   // SAM cigar operation codes
   localparam logic [3:0] CIGAR_MATCH = 4'd0;
   localparam logic [3:0] CIGAR_INS   = 4'd1;
   localparam logic [3:0] CIGAR_DEL   = 4'd2;
   localparam logic [3:0] CIGAR_SKIP  = 4'd3;
   localparam logic [3:0] CIGAR_SOFT  = 4'd4;
   localparam logic [3:0] CIGAR_EQUAL = 4'd7;
   localparam logic [3:0] CIGAR_DIFF  = 4'd8;

   // Result support codes
   localparam logic [1:0] SUPPORT_UNKNOWN = 2'd0;
   localparam logic [1:0] SUPPORT_REF     = 2'd1;
   localparam logic [1:0] SUPPORT_ALT     = 2'd2;

   // Result reason codes
   localparam logic [2:0] REASON_NONE        = 3'd0;
   localparam logic [2:0] REASON_NOT_COVERED = 3'd1;
   localparam logic [2:0] REASON_IN_DELETION = 3'd2;
   localparam logic [2:0] REASON_LOW_QUALITY = 3'd3;
   localparam logic [2:0] REASON_NEITHER     = 3'd4;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_CIGAR,
      KIND_BASE
   } kind_type;

   // Cigar classes: align moves both cursors, read moves the read cursor,
   // gap moves the reference cursor
   typedef enum logic [1:0] {
      OPC_ALIGN,
      OPC_READ,
      OPC_GAP
   } op_class_type;

   typedef enum logic [2:0] {
      WALK_SEARCH,
      WALK_FOUND,
      WALK_CAPTURED,
      WALK_DELETION,
      WALK_INVALID,
      WALK_DONE
   } walk_type;

   // Classified item passed from front end to back end
   typedef struct packed {
      kind_type              kind;
      op_class_type          op_class;
      logic [LEN_BITS-1:0]   op_length;
      logic [REM_BITS-1:0]   remain;
      logic                  invalid_pos;
      logic [7:0]            ref_allele;
      logic [7:0]            alt_allele;
      logic [3:0]            base_code;
      logic [7:0]            base_quality;
      logic                  last;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Decode a 4-bit nucleotide code to its ASCII character
   function automatic logic [7:0] nt16_char(input logic [3:0] code);
      logic [7:0] c;
      case (code)
         4'd0:    c = "=";
         4'd1:    c = "A";
         4'd2:    c = "C";
         4'd3:    c = "M";
         4'd4:    c = "G";
         4'd5:    c = "R";
         4'd6:    c = "S";
         4'd7:    c = "V";
         4'd8:    c = "T";
         4'd9:    c = "W";
         4'd10:   c = "Y";
         4'd11:   c = "H";
         4'd12:   c = "K";
         4'd13:   c = "D";
         4'd14:   c = "B";
         default: c = "N";
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cigar_walk_variant_allele_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one input transaction per cycle while the queue has room; one walk step per
// cycle while the result register is free. A last base passes the queue, then the result
// register, before rsp_tvalid rises. The 4-entry queue takes input while rsp_tready stalls.
// Reset (synchronous): walk searching, cursors and alleles zero, min quality 0, queue empty.
// ---------------------------------------------------------------------------------------------
// Variant allele check by cigar walk
// Locates the read base at a variant position and reports allele support per read.
// ---------------------------------------------------------------------------------------------
module cigar_walk_variant_allele_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [7:0]                          csr_write_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // align_start[30:0], snv_position[62:31], ref_allele[70:63], alt_allele[78:71],
   // op_code[82:79], op_length[110:83], base_code[114:111], base_quality[122:115]
   input  logic [cwvac_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // support[1:0], reason[4:2], seq_offset[36:5]
   output logic [cwvac_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic                                keep;
   logic                                q_push;
   logic                                q_pop;
   cwvac_pkg::item_type                 front_item;
   cwvac_pkg::item_type                 q_item;
   cwvac_pkg::queue_status_type         q_status;

   // Accept while the queue has room; drop items without effect
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready && keep;

   cwvac_front u_front (
      .req_data   (req_tdata),
      .req_action (req_tuser),
      .req_last   (req_tlast),
      .keep       (keep),
      .item       (front_item)
   );

   cwvac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .status    (q_status)
   );

   cwvac_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_status       (q_status),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   // Never push into a full queue
   assert property (@(posedge clock) disable iff (reset) q_status.full |-> !q_push)
      else $error("push into full queue");

   // Never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // A new result follows a popped last base
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(q_pop && (q_item.kind == cwvac_pkg::KIND_BASE) && q_item.last))
      else $error("result without last base");

   // Uncovered and deleted positions carry no offset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tdata[4:2] == cwvac_pkg::REASON_NOT_COVERED)
                      || (rsp_tdata[4:2] == cwvac_pkg::REASON_IN_DELETION)))
      |-> (rsp_tdata[36:5] == '0))
      else $error("offset set for uncovered position");

endmodule
`default_nettype wire

// ===== hw/rtl/cwvac_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Variant allele check front end
// Unpacks an incoming transaction, classifies it and prepares the header arithmetic.
// ---------------------------------------------------------------------------------------------
module cwvac_front (
   input  logic [cwvac_pkg::REQ_DATA_BITS-1:0] req_data,
   input  logic [1:0]                          req_action,
   input  logic                                req_last,
   output logic                                keep,
   output cwvac_pkg::item_type                 item
);

   logic [30:0]                         align_start;
   logic [31:0]                         snv_position;
   logic [7:0]                          ref_allele;
   logic [7:0]                          alt_allele;
   logic [3:0]                          op_code;
   logic [cwvac_pkg::LEN_BITS-1:0]      op_length;
   logic [3:0]                          base_code;
   logic [7:0]                          base_quality;
   logic [30:0]                         target_pos;

   // Unpack payload fields
   assign align_start  = req_data[30:0];
   assign snv_position = req_data[62:31];
   assign ref_allele   = req_data[70:63];
   assign alt_allele   = req_data[78:71];
   assign op_code      = req_data[82:79];
   assign op_length    = req_data[110:83];
   assign base_code    = req_data[114:111];
   assign base_quality = req_data[122:115];

   // Convert the 1-based position to 0-based
   assign target_pos = snv_position[30:0] - 31'd1;

   // Classify and drop items that have no effect
   always_comb begin
      item              = '0;
      keep              = 1'b0;
      item.op_length    = op_length;
      item.ref_allele   = ref_allele;
      item.alt_allele   = alt_allele;
      item.base_code    = base_code;
      item.base_quality = base_quality;
      item.last         = req_last;
      item.invalid_pos  = (snv_position == 32'd0) || snv_position[31];
      item.remain       = cwvac_pkg::REM_BITS'(target_pos)
                          - cwvac_pkg::REM_BITS'(align_start);
      case (req_action)
         cwvac_pkg::ACTION_HEADER: begin
            keep      = 1'b1;
            item.kind = cwvac_pkg::KIND_HEADER;
         end
         cwvac_pkg::ACTION_CIGAR: begin
            item.kind = cwvac_pkg::KIND_CIGAR;
            case (op_code)
               cwvac_pkg::CIGAR_MATCH, cwvac_pkg::CIGAR_EQUAL, cwvac_pkg::CIGAR_DIFF: begin
                  keep          = 1'b1;
                  item.op_class = cwvac_pkg::OPC_ALIGN;
               end
               cwvac_pkg::CIGAR_INS, cwvac_pkg::CIGAR_SOFT: begin
                  keep          = 1'b1;
                  item.op_class = cwvac_pkg::OPC_READ;
               end
               cwvac_pkg::CIGAR_DEL, cwvac_pkg::CIGAR_SKIP: begin
                  keep          = 1'b1;
                  item.op_class = cwvac_pkg::OPC_GAP;
               end
               default: begin
                  // hard clip, pad and unknown codes do nothing
                  keep = 1'b0;
               end
            endcase
         end
         cwvac_pkg::ACTION_BASE: begin
            keep      = 1'b1;
            item.kind = cwvac_pkg::KIND_BASE;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cwvac_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Variant allele check item queue
// Short first-in first-out buffer that decouples the front end from the back end.
// ---------------------------------------------------------------------------------------------
module cwvac_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  cwvac_pkg::item_type           push_item,
   input  logic                          pop,
   output cwvac_pkg::item_type           pop_item,
   output cwvac_pkg::queue_status_type   status
);

   cwvac_pkg::item_type                   mem_ff [cwvac_pkg::QUEUE_DEPTH];
   logic [cwvac_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cwvac_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cwvac_pkg::QUEUE_PTR_BITS:0]    count_ff, count_in;

   // Report fill status
   assign status.full  = (count_ff == (cwvac_pkg::QUEUE_PTR_BITS + 1)'(cwvac_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cwvac_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------------------------
// Variant allele check back end
// Walks the cigar, captures the base at the variant offset and registers the result.
// ---------------------------------------------------------------------------------------------
module cwvac_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [7:0]                          csr_write_data,
   input  cwvac_pkg::queue_status_type         q_status,
   input  cwvac_pkg::item_type                 q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cwvac_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   cwvac_pkg::walk_type                  walk_ff, walk_in;
   logic [cwvac_pkg::REM_BITS-1:0]       remain_ff, remain_in;
   logic [cwvac_pkg::POS_BITS-1:0]       seq_ff, seq_in;
   logic [cwvac_pkg::POS_BITS-1:0]       toff_ff, toff_in;
   logic [cwvac_pkg::POS_BITS-1:0]       count_ff, count_in;
   logic [7:0]                           ref_ff, ref_in;
   logic [7:0]                           alt_ff, alt_in;
   logic [3:0]                           cap_code_ff, cap_code_in;
   logic [7:0]                           cap_qual_ff, cap_qual_in;
   logic [7:0]                           min_qual_ff, min_qual_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]                           support_ff, support_in;
   logic [2:0]                           reason_ff, reason_in;
   logic [cwvac_pkg::OFFSET_BITS-1:0]    offset_ff, offset_in;

   logic                                 is_header, is_cigar, is_base;
   logic [cwvac_pkg::REM_BITS-1:0]       remain_diff;
   logic                                 hit;
   logic                                 capture_now;
   logic                                 result_load;
   logic [cwvac_pkg::POS_BITS-1:0]       hit_offset;
   logic [cwvac_pkg::POS_BITS-1:0]       seq_plus_len;
   logic [cwvac_pkg::POS_BITS-1:0]       count_next;
   logic [3:0]                           eff_code;
   logic [7:0]                           eff_qual;
   logic [7:0]                           eff_char;

   // Clamp a widened sum to the cursor range
   function automatic logic [cwvac_pkg::POS_BITS-1:0] sat_pos(
      input logic [cwvac_pkg::SUM_BITS-1:0] s
   );
      logic [cwvac_pkg::POS_BITS-1:0] r;
      if (|s[cwvac_pkg::SUM_BITS-1:cwvac_pkg::POS_BITS]) begin
         r = '1;
      end else begin
         r = s[cwvac_pkg::POS_BITS-1:0];
      end
      return r;
   endfunction

   // Pop when the result register can take a transaction
   assign q_pop     = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign is_header = q_pop && (q_item.kind == cwvac_pkg::KIND_HEADER);
   assign is_cigar  = q_pop && (q_item.kind == cwvac_pkg::KIND_CIGAR);
   assign is_base   = q_pop && (q_item.kind == cwvac_pkg::KIND_BASE);

   // Distance to the variant; once negative the position lies behind the cursor
   assign remain_diff  = remain_ff - cwvac_pkg::REM_BITS'(q_item.op_length);
   assign hit          = !remain_ff[cwvac_pkg::REM_BITS-1] && remain_diff[cwvac_pkg::REM_BITS-1];
   assign hit_offset   = sat_pos(cwvac_pkg::SUM_BITS'(seq_ff)
                                 + cwvac_pkg::SUM_BITS'(remain_ff[cwvac_pkg::REM_BITS-2:0]));
   assign seq_plus_len = sat_pos(cwvac_pkg::SUM_BITS'(seq_ff)
                                 + cwvac_pkg::SUM_BITS'(q_item.op_length));
   assign count_next   = (&count_ff) ? count_ff : count_ff + cwvac_pkg::POS_BITS'(1);
   assign capture_now  = is_base && (walk_ff == cwvac_pkg::WALK_FOUND) && (count_ff == toff_ff);

   // Walk state: next state
   always_comb begin
      walk_in = walk_ff;
      if (is_header) begin
         walk_in = q_item.invalid_pos ? cwvac_pkg::WALK_INVALID : cwvac_pkg::WALK_SEARCH;
      end else if (is_cigar && (walk_ff == cwvac_pkg::WALK_SEARCH) && hit) begin
         case (q_item.op_class)
            cwvac_pkg::OPC_ALIGN: walk_in = cwvac_pkg::WALK_FOUND;
            cwvac_pkg::OPC_GAP:   walk_in = cwvac_pkg::WALK_DELETION;
            default:              walk_in = walk_ff;
         endcase
      end else if (is_base && (walk_ff != cwvac_pkg::WALK_DONE)) begin
         if (q_item.last) begin
            walk_in = cwvac_pkg::WALK_DONE;
         end else if (capture_now) begin
            walk_in = cwvac_pkg::WALK_CAPTURED;
         end
      end
   end

   // Walk state: result outputs
   always_comb begin
      result_load = is_base && (walk_ff != cwvac_pkg::WALK_DONE) && q_item.last;
      eff_code    = capture_now ? q_item.base_code : cap_code_ff;
      eff_qual    = capture_now ? q_item.base_quality : cap_qual_ff;
      eff_char    = cwvac_pkg::nt16_char(eff_code);
      support_in  = cwvac_pkg::SUPPORT_UNKNOWN;
      reason_in   = cwvac_pkg::REASON_NOT_COVERED;
      offset_in   = '0;
      if (walk_ff == cwvac_pkg::WALK_DELETION) begin
         reason_in = cwvac_pkg::REASON_IN_DELETION;
      end else if ((walk_ff == cwvac_pkg::WALK_CAPTURED) || capture_now) begin
         offset_in = cwvac_pkg::OFFSET_BITS'(toff_ff);
         if (eff_qual < min_qual_ff) begin
            reason_in = cwvac_pkg::REASON_LOW_QUALITY;
         end else if (eff_char == alt_ff) begin
            support_in = cwvac_pkg::SUPPORT_ALT;
            reason_in  = cwvac_pkg::REASON_NONE;
         end else if (eff_char == ref_ff) begin
            support_in = cwvac_pkg::SUPPORT_REF;
            reason_in  = cwvac_pkg::REASON_NONE;
         end else begin
            reason_in = cwvac_pkg::REASON_NEITHER;
         end
      end
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Cursor and capture datapath
   always_comb begin
      remain_in   = remain_ff;
      seq_in      = seq_ff;
      toff_in     = toff_ff;
      count_in    = count_ff;
      ref_in      = ref_ff;
      alt_in      = alt_ff;
      cap_code_in = cap_code_ff;
      cap_qual_in = cap_qual_ff;
      min_qual_in = csr_write_en ? csr_write_data : min_qual_ff;
      if (is_header) begin
         remain_in   = q_item.remain;
         seq_in      = '0;
         toff_in     = '0;
         count_in    = '0;
         ref_in      = q_item.ref_allele;
         alt_in      = q_item.alt_allele;
         cap_code_in = '0;
         cap_qual_in = '0;
      end else if (is_cigar && (walk_ff == cwvac_pkg::WALK_SEARCH)) begin
         case (q_item.op_class)
            cwvac_pkg::OPC_ALIGN: begin
               if (hit) begin
                  toff_in = hit_offset;
               end else begin
                  if (!remain_ff[cwvac_pkg::REM_BITS-1]) begin
                     remain_in = remain_diff;
                  end
                  seq_in = seq_plus_len;
               end
            end
            cwvac_pkg::OPC_READ: begin
               seq_in = seq_plus_len;
            end
            cwvac_pkg::OPC_GAP: begin
               if (!hit && !remain_ff[cwvac_pkg::REM_BITS-1]) begin
                  remain_in = remain_diff;
               end
            end
            default: begin
               seq_in = seq_ff;
            end
         endcase
      end else if (is_base && (walk_ff != cwvac_pkg::WALK_DONE)) begin
         count_in = count_next;
         if (capture_now) begin
            cap_code_in = q_item.base_code;
            cap_qual_in = q_item.base_quality;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff      <= cwvac_pkg::WALK_SEARCH;
         remain_ff    <= '0;
         seq_ff       <= '0;
         toff_ff      <= '0;
         count_ff     <= '0;
         ref_ff       <= '0;
         alt_ff       <= '0;
         cap_code_ff  <= '0;
         cap_qual_ff  <= '0;
         min_qual_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         walk_ff      <= walk_in;
         remain_ff    <= remain_in;
         seq_ff       <= seq_in;
         toff_ff      <= toff_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         alt_ff       <= alt_in;
         cap_code_ff  <= cap_code_in;
         cap_qual_ff  <= cap_qual_in;
         min_qual_ff  <= min_qual_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result payload until replaced
   always_ff @(posedge clock) begin
      if (result_load) begin
         support_ff <= support_in;
         reason_ff  <= reason_in;
         offset_ff  <= offset_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = cwvac_pkg::RSP_DATA_BITS'({offset_ff, reason_ff, support_ff});

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------------------------
// Variant allele check testbench
// Streams read headers, cigar operations and bases into the cigar walk block and scores
// every verdict against a cycle-free walk of the same reads. It covers directed corner
// cases, cursor saturation, quality threshold settings, a long result stall and three
// random phases with different idle patterns on both stream sides.
// ---------------------------------------------------------------------------------------------
module tb_top;
   import cwvac_pkg::*;

   // Cigar codes the package leaves out
   localparam logic [3:0] CIGAR_HARD_CLIP = 4'd5;
   localparam logic [3:0] CIGAR_PAD       = 4'd6;
   localparam logic [3:0] CIGAR_BOGUS     = 4'd15;

   // Nucleotide codes used by the directed reads
   localparam logic [3:0] NT_A = 4'd1;
   localparam logic [3:0] NT_C = 4'd2;
   localparam logic [3:0] NT_G = 4'd4;
   localparam logic [3:0] NT_T = 4'd8;

   localparam logic [7:0] NT16_CHARS [16] = '{"=", "A", "C", "M", "G", "R", "S", "V",
                                              "T", "W", "Y", "H", "K", "D", "B", "N"};
   localparam logic [7:0] ALLELE_POOL [4] = '{"A", "C", "G", "T"};
   localparam logic [3:0] BASE_POOL [4]   = '{NT_A, NT_C, NT_G, NT_T};

   localparam longint unsigned READ_POS_MAX = (64'd1 << POS_BITS) - 1;
   localparam longint unsigned REF_POS_MAX  = (64'd1 << 33) - 1;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int STALL_CYCLES   = 150;

   typedef struct {
      logic [1:0]  action;
      logic [30:0] align_start;
      logic [31:0] snv_position;
      logic [7:0]  ref_allele;
      logic [7:0]  alt_allele;
      logic [3:0]  op_code;
      logic [27:0] op_length;
      logic [3:0]  base_code;
      logic [7:0]  base_quality;
      logic        last;
   } read_item_type;

   typedef struct {
      logic [1:0]  support;
      logic [2:0]  reason;
      logic [31:0] seq_offset;
   } verdict_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_en = 1'b0;
   logic [7:0]               csr_write_data = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0]               req_tuser = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // Walk state of the predictor
   logic [32:0]         walk_ref_pos;
   logic [POS_BITS-1:0] walk_read_pos;
   logic [POS_BITS-1:0] variant_offset;
   logic [POS_BITS-1:0] bases_seen;
   logic [31:0]         variant_ref_pos;
   walk_type            walk_state;
   logic [7:0]          ref_char;
   logic [7:0]          alt_char;
   logic [3:0]          held_code;
   logic [7:0]          held_quality;
   logic [7:0]          quality_floor;

   verdict_type pending_verdicts[$];
   int       send_idle_pct;
   int       recv_idle_pct;
   int       rsp_hold_request;
   int       mismatch_count;
   int       items_sent;
   int       reads_sent;
   int       verdicts_checked;
   int       quiet_cycles;

   cigar_walk_variant_allele_check dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Saturating add on the cursors
   function automatic longint unsigned clamp_sum(input longint unsigned a,
                                                 input longint unsigned b,
                                                 input longint unsigned cap);
      longint unsigned s;
      s = a + b;
      return (s > cap) ? cap : s;
   endfunction

   // Advance the walk by one accepted item; returns 1 when it yields a verdict
   function automatic bit predict_verdict(input read_item_type it, output verdict_type v);
      longint unsigned len;
      bit              hit;
      logic [7:0]      seen_char;
      v = '{support: SUPPORT_UNKNOWN, reason: REASON_NONE, seq_offset: '0};
      case (it.action)
         ACTION_HEADER: begin
            walk_ref_pos   = 33'(it.align_start);
            walk_read_pos  = '0;
            variant_offset = '0;
            bases_seen     = '0;
            held_code      = '0;
            held_quality   = '0;
            ref_char       = it.ref_allele;
            alt_char       = it.alt_allele;
            if (it.snv_position == 0 || it.snv_position > 32'h7FFF_FFFF) begin
               variant_ref_pos = '0;
               walk_state      = WALK_INVALID;
            end else begin
               variant_ref_pos = it.snv_position - 32'd1;
               walk_state      = WALK_SEARCH;
            end
            return 1'b0;
         end
         ACTION_CIGAR: begin
            if (walk_state != WALK_SEARCH) return 1'b0;
            len = it.op_length;
            hit = (64'(walk_ref_pos) <= 64'(variant_ref_pos)) &&
                  (64'(variant_ref_pos) < 64'(walk_ref_pos) + len);
            case (it.op_code)
               CIGAR_MATCH, CIGAR_EQUAL, CIGAR_DIFF: begin
                  if (hit) begin
                     variant_offset = POS_BITS'(clamp_sum(64'(walk_read_pos),
                        64'(variant_ref_pos) - 64'(walk_ref_pos), READ_POS_MAX));
                     walk_state = WALK_FOUND;
                  end else begin
                     walk_ref_pos  = 33'(clamp_sum(64'(walk_ref_pos), len, REF_POS_MAX));
                     walk_read_pos = POS_BITS'(clamp_sum(64'(walk_read_pos), len,
                                                         READ_POS_MAX));
                  end
               end
               CIGAR_INS, CIGAR_SOFT: begin
                  walk_read_pos = POS_BITS'(clamp_sum(64'(walk_read_pos), len, READ_POS_MAX));
               end
               CIGAR_DEL, CIGAR_SKIP: begin
                  if (hit) walk_state = WALK_DELETION;
                  else walk_ref_pos = 33'(clamp_sum(64'(walk_ref_pos), len, REF_POS_MAX));
               end
               default: ;
            endcase
            return 1'b0;
         end
         ACTION_BASE: begin
            if (walk_state == WALK_DONE) return 1'b0;
            if (walk_state == WALK_FOUND && bases_seen == variant_offset) begin
               held_code    = it.base_code;
               held_quality = it.base_quality;
               walk_state   = WALK_CAPTURED;
            end
            bases_seen = POS_BITS'(clamp_sum(64'(bases_seen), 64'd1, READ_POS_MAX));
            if (!it.last) return 1'b0;
            seen_char = NT16_CHARS[held_code];
            if (walk_state == WALK_DELETION) begin
               v.reason = REASON_IN_DELETION;
            end else if (walk_state != WALK_CAPTURED) begin
               v.reason = REASON_NOT_COVERED;
            end else begin
               v.seq_offset = 32'(variant_offset);
               if (held_quality < quality_floor) v.reason = REASON_LOW_QUALITY;
               else if (seen_char == alt_char) v.support = SUPPORT_ALT;
               else if (seen_char == ref_char) v.support = SUPPORT_REF;
               else v.reason = REASON_NEITHER;
            end
            walk_state = WALK_DONE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Offer one transaction, with random idle cycles ahead of it, and predict on acceptance
   task automatic offer_item(input read_item_type it);
      verdict_type v;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tlast  <= it.last;
      req_tdata  <= {5'd0, it.base_quality, it.base_code, it.op_length, it.op_code,
                     it.alt_allele, it.ref_allele, it.snv_position, it.align_start};
      do @(posedge clock); while (!req_tready);
      if (predict_verdict(it, v)) pending_verdicts.push_back(v);
      items_sent++;
   endtask

   task automatic send_header(input logic [30:0] start_pos, input logic [31:0] snv,
                              input logic [7:0] ref_c, input logic [7:0] alt_c);
      read_item_type it;
      it = '{default: '0};
      it.action       = ACTION_HEADER;
      it.align_start  = start_pos;
      it.snv_position = snv;
      it.ref_allele   = ref_c;
      it.alt_allele   = alt_c;
      offer_item(it);
   endtask

   task automatic send_cigar(input logic [3:0] op, input logic [27:0] len);
      read_item_type it;
      it = '{default: '0};
      it.action    = ACTION_CIGAR;
      it.op_code   = op;
      it.op_length = len;
      offer_item(it);
   endtask

   task automatic send_base(input logic [3:0] code, input logic [7:0] quality,
                            input logic last);
      read_item_type it;
      it = '{default: '0};
      it.action       = ACTION_BASE;
      it.base_code    = code;
      it.base_quality = quality;
      it.last         = last;
      offer_item(it);
   endtask

   // One-base read whose variant sits on the first aligned base
   task automatic send_short_read(input logic [30:0] start_pos, input logic [7:0] ref_c,
                                  input logic [7:0] alt_c, input logic [3:0] code,
                                  input logic [7:0] quality);
      send_header(start_pos, 32'(start_pos) + 32'd1, ref_c, alt_c);
      send_cigar(CIGAR_MATCH, 28'd4);
      send_base(code, quality, 1'b1);
      reads_sent++;
   endtask

   // Hold the input idle until every verdict is back, then let the pipeline settle
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_quality(input logic [7:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      quality_floor = value;
   endtask

   function automatic logic [7:0] random_allele();
      return ($urandom_range(99) < 8) ? 8'($urandom) : ALLELE_POOL[$urandom_range(3)];
   endfunction

   function automatic logic [3:0] random_base_code();
      return ($urandom_range(99) < 75) ? BASE_POOL[$urandom_range(3)] : 4'($urandom);
   endfunction

   function automatic logic [7:0] random_quality();
      return ($urandom_range(99) < 85) ? 8'($urandom_range(60)) : 8'($urandom);
   endfunction

   // One random read: mostly well formed, sometimes reordered, truncated or trailed by noise
   task automatic send_random_read();
      logic [3:0]      op_list [6];
      logic [27:0]     len_list [6];
      int              n_ops;
      int              n_bases;
      int              n_early;
      int              mode;
      int              pick;
      longint unsigned ref_span;
      longint unsigned read_span;
      longint unsigned spot;
      logic [30:0]     start_pos;
      logic [31:0]     snv;
      n_ops     = $urandom_range(1, 6);
      ref_span  = 0;
      read_span = 0;
      for (int i = 0; i < n_ops; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) op_list[i] = CIGAR_MATCH;
         else if (pick < 48) op_list[i] = CIGAR_EQUAL;
         else if (pick < 56) op_list[i] = CIGAR_DIFF;
         else if (pick < 64) op_list[i] = CIGAR_INS;
         else if (pick < 72) op_list[i] = CIGAR_DEL;
         else if (pick < 78) op_list[i] = CIGAR_SKIP;
         else if (pick < 86) op_list[i] = CIGAR_SOFT;
         else if (pick < 91) op_list[i] = CIGAR_HARD_CLIP;
         else if (pick < 95) op_list[i] = CIGAR_PAD;
         else op_list[i] = 4'($urandom_range(9, 15));
         len_list[i] = ($urandom_range(99) < 4) ? 28'($urandom) : 28'($urandom_range(8));
         case (op_list[i])
            CIGAR_MATCH, CIGAR_EQUAL, CIGAR_DIFF: begin
               ref_span  += len_list[i];
               read_span += len_list[i];
            end
            CIGAR_INS, CIGAR_SOFT: read_span += len_list[i];
            CIGAR_DEL, CIGAR_SKIP: ref_span += len_list[i];
            default: ;
         endcase
      end
      start_pos = ($urandom_range(99) < 10) ? 31'($urandom) : 31'($urandom_range(5000));
      pick = $urandom_range(99);
      if (pick < 80) begin
         spot = (ref_span == 0) ? 0 : (64'($urandom) % (ref_span + 1));
         snv  = 32'(64'(start_pos) + 1 + spot);
      end else if (pick < 86) begin
         snv = '0;
      end else if (pick < 93) begin
         snv = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
      end else begin
         snv = $urandom;
      end
      if (read_span == 0 || read_span > 24) n_bases = $urandom_range(1, 24);
      else n_bases = int'(read_span);
      if ($urandom_range(99) < 15) n_bases = $urandom_range(1, 30);
      mode    = $urandom_range(99);
      n_early = (mode < 8 && n_bases > 1) ? $urandom_range(1, n_bases - 1) : 0;

      send_header(start_pos, snv, random_allele(), random_allele());
      for (int i = 0; i < n_early; i++) send_base(random_base_code(), random_quality(), 1'b0);
      for (int i = 0; i < n_ops; i++) send_cigar(op_list[i], len_list[i]);
      for (int i = n_early; i < n_bases; i++) begin
         send_base(random_base_code(), random_quality(),
                   (i == n_bases - 1) && !(mode >= 8 && mode < 12));
      end
      // trailing noise after the verdict
      if (mode >= 12 && mode < 16) begin
         send_cigar(CIGAR_MATCH, 28'($urandom_range(8)));
         send_base(random_base_code(), random_quality(), 1'b1);
      end
      reads_sent++;
   endtask

   task automatic test_special_cases();
      // no header yet: variant at reference 0 with empty alleles
      send_cigar(CIGAR_MATCH, 28'd1);
      send_base(NT_A, 8'd255, 1'b1);
      // stray items after the verdict are dropped
      send_cigar(CIGAR_EQUAL, 28'd3);
      send_base(NT_A, 8'd40, 1'b1);
      // variant position zero, then one beyond the signed range
      send_header(31'd5, 32'd0, "A", "C");
      send_base(NT_C, 8'd40, 1'b1);
      send_header(31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
      send_base(4'hF, 8'hFF, 1'b1);
      // clips, pad, unknown op and zero length skipped; equal hits, later deletion ignored
      send_header(31'd10, 32'd12, "A", "G");
      send_cigar(CIGAR_SOFT, 28'd2);
      send_cigar(CIGAR_HARD_CLIP, 28'd7);
      send_cigar(CIGAR_PAD, 28'd4);
      send_cigar(CIGAR_BOGUS, 28'd9);
      send_cigar(CIGAR_MATCH, 28'd0);
      send_cigar(CIGAR_DIFF, 28'd1);
      send_cigar(CIGAR_EQUAL, 28'd5);
      send_cigar(CIGAR_DEL, 28'd3);
      repeat (3) send_base(NT_A, 8'd30, 1'b0);
      send_base(NT_G, 8'd30, 1'b1);
      // variant inside a deletion
      send_header(31'd0, 32'd3, "C", "T");
      send_cigar(CIGAR_MATCH, 28'd2);
      send_cigar(CIGAR_DEL, 28'd2);
      send_base(NT_C, 8'd30, 1'b1);
      // variant before the alignment
      send_header(31'd100, 32'd50, "C", "T");
      send_cigar(CIGAR_MATCH, 28'd10);
      send_base(NT_C, 8'd30, 1'b1);
      // offset beyond the bases received
      send_header(31'd0, 32'd6, "C", "T");
      send_cigar(CIGAR_MATCH, 28'd10);
      send_base(NT_C, 8'd30, 1'b0);
      send_base(NT_C, 8'd30, 1'b1);
      // cigar arrives after the offset has already streamed past
      send_header(31'd0, 32'd1, "C", "T");
      send_base(NT_C, 8'd30, 1'b0);
      send_base(NT_C, 8'd30, 1'b0);
      send_cigar(CIGAR_MATCH, 28'd5);
      send_base(NT_C, 8'd30, 1'b1);
      // late cigar still in time, with an insertion ahead of the match
      send_header(31'd0, 32'd2, "C", "T");
      send_base(NT_A, 8'd30, 1'b0);
      send_cigar(CIGAR_INS, 28'd1);
      send_cigar(CIGAR_MATCH, 28'd3);
      send_base(NT_A, 8'd30, 1'b0);
      send_base(NT_C, 8'd30, 1'b1);
      reads_sent += 9;
   endtask

   // Long operations push both cursors into saturation; a wrapping cursor would hit
   task automatic test_cursor_saturation();
      send_header(31'h7FFF_FFFF, 32'h0FFF_FFF1, "A", "C");
      repeat (26) send_cigar(CIGAR_DEL, 28'hFFF_FFFF);
      send_cigar(CIGAR_MATCH, 28'hFFF_FFFF);
      repeat (10) send_base(NT_C, 8'd50, 1'b0);
      send_base(NT_A, 8'd50, 1'b1);
      send_header(31'd0, 32'd1, "A", "C");
      repeat (16) send_cigar(CIGAR_INS, 28'hFFF_FFFF);
      send_cigar(CIGAR_SOFT, 28'h20);
      send_cigar(CIGAR_MATCH, 28'd4);
      repeat (16) send_base(NT_C, 8'd50, 1'b0);
      send_base(NT_A, 8'd50, 1'b1);
      reads_sent += 2;
   endtask

   task automatic test_quality_threshold();
      write_min_quality(8'd255);
      send_short_read(31'd7, "G", "T", NT_G, 8'd254);
      send_short_read(31'd7, "G", "T", NT_G, 8'd255);
      write_min_quality(8'd0);
      send_short_read(31'd9, "G", "T", NT_T, 8'd0);
      write_min_quality(8'd31);
      send_short_read(31'd3, "G", "T", NT_T, 8'd30);
      send_short_read(31'd3, "G", "T", NT_T, 8'd31);
      send_short_read(31'd3, "G", "T", NT_C, 8'd200);
      send_short_read(31'd3, "A", "A", NT_A, 8'd40);
      write_min_quality(8'($urandom_range(1, 254)));
      send_short_read(31'd3, "G", "T", NT_G, random_quality());
   endtask

   // Receiver holds off while reads keep coming, then the sender waits for every verdict
   task automatic test_result_stall();
      rsp_hold_request = STALL_CYCLES;
      repeat (15) send_short_read(31'($urandom_range(5000)), random_allele(), random_allele(),
                                  random_base_code(), random_quality());
      wait_for_drain();
   endtask

   task automatic test_random_reads(input int sender_pct, input int receiver_pct,
                                    input logic [7:0] floor_value, input int budget);
      int stop_at;
      write_min_quality(floor_value);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) send_random_read();
   endtask

   // Drive the receiver: random idling plus an occasional long hold-off
   always @(negedge clock) begin : drive_rsp_ready
      static int hold_left = 0;
      if (rsp_hold_request > 0) begin
         hold_left        = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Score each accepted verdict against the oldest prediction
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("verdict with none expected: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_tdata[1:0] !== want.support) begin
               $error("support mismatch: expected %0d, got %0d", want.support, rsp_tdata[1:0]);
               mismatch_count++;
            end
            if (rsp_tdata[4:2] !== want.reason) begin
               $error("reason mismatch: expected %0d, got %0d", want.reason, rsp_tdata[4:2]);
               mismatch_count++;
            end
            if (rsp_tdata[36:5] !== want.seq_offset) begin
               $error("seq_offset mismatch: expected %0d, got %0d",
                      want.seq_offset, rsp_tdata[36:5]);
               mismatch_count++;
            end
         end
      end
   end

   // Abort when neither side has moved a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      walk_ref_pos     = '0;
      walk_read_pos    = '0;
      variant_offset   = '0;
      bases_seen       = '0;
      variant_ref_pos  = '0;
      walk_state       = WALK_SEARCH;
      ref_char         = '0;
      alt_char         = '0;
      held_code        = '0;
      held_quality     = '0;
      quality_floor    = '0;
      send_idle_pct    = 28;
      recv_idle_pct    = 54;
      rsp_hold_request = 0;
      mismatch_count   = 0;
      items_sent       = 0;
      reads_sent       = 0;
      verdicts_checked = 0;
      quiet_cycles     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_cursor_saturation();
      test_quality_threshold();
      test_result_stall();
      test_random_reads(28, 54, 8'd20, 415);
      test_random_reads(54, 28, 8'($urandom_range(1, 254)), 415);
      test_random_reads(0, 0, 8'd0, 415);
      wait_for_drain();

      $display("Covered %0d transactions over %0d reads, %0d verdicts checked",
               items_sent, reads_sent, verdicts_checked);
      $display("Included corner reads, cursor saturation, quality floors and a result stall");
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cwvac_pkg.sv
hw/rtl/cwvac_front.sv
hw/rtl/cwvac_queue.sv
hw/rtl/cwvac_back.sv
hw/rtl/cigar_walk_variant_allele_check.sv
tb/sv/tb_top.sv
